### rtl/deq_pkg.sv
// Shared constants, operation and status codes, and the result record of the deque.
// Used by deq_core and by the double_ended_queue top level.
package deq_pkg;

    localparam int DEPTH     = 16;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int OUT_CNT_W = 5;
    localparam int SEL_W     = 2;
    localparam int OUT_TDATA_W = ((DATA_W + OUT_CNT_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PEEK_BACK  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Where the result data comes from.
    localparam logic [SEL_W-1:0] SEL_ZERO  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_EMPTY = 2'd1;
    localparam logic [SEL_W-1:0] SEL_MEM   = 2'd2;

    localparam logic [DATA_W-1:0] EMPTY_DATA = '1;

    typedef struct packed {
        logic [SEL_W-1:0]    sel;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    count;
    } res_t;

endpackage

### rtl/double_ended_queue.sv
// Top level of the bounded deque: stream handshake on both sides and the result register.
// Depends on deq_pkg and instantiates deq_core, which holds the ring store.
//
// The deque holds up to DEPTH (16) signed 32-bit values in a one-port synchronous memory.
// Every request (push front/back, pop front/back, peek front/back) gives exactly one result
// with the data, a status and the count after the operation. A request updates the pointers
// and reads or writes the store in its accept cycle; the registered read data is moved into
// the output register once that register is empty or being taken, so a result passes both registers.
// A new request is taken in the same cycle as the previous result is loaded, which sustains
// one request per cycle while the output side takes results; the single store port and the
// one-deep output register set that limit. Pops and peeks of an empty deque answer -1 with
// the empty status; a push into a full deque is dropped with the full status.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,   // [31:0] value
    input  logic [KIND_W-1:0]      s_tuser,   // [2:0] kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] data, [36:32] count, rest zero
    output logic [STATUS_W-1:0]    m_tuser    // [1:0] status
);

    logic                  busy_reg, busy_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]     data_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [OUT_CNT_W-1:0]  count_reg;

    logic                  out_free, accept, load;
    logic [DATA_W-1:0]     rd_data;
    logic [DATA_W-1:0]     data_mux;
    res_t                  res;

    assign out_free = !m_tvalid_reg || m_tready;
    assign load     = busy_reg && out_free;
    assign s_tready = !busy_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    deq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .op_en   (accept),
        .kind    (s_tuser),
        .value   (s_tdata),
        .rd_data (rd_data),
        .res     (res)
    );

    always_comb
    begin
        case (res.sel)
            SEL_MEM:   data_mux = rd_data;
            SEL_EMPTY: data_mux = EMPTY_DATA;
            default:   data_mux = '0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (load)
        begin
            busy_next = 1'b0;
        end

        m_tvalid_next = m_tvalid_reg;
        if (load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg   <= data_mux;
            status_reg <= res.status;
            count_reg  <= OUT_CNT_W'(res.count);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_TDATA_W - DATA_W - OUT_CNT_W)'(0), count_reg, data_reg};
    assign m_tuser  = status_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> busy_reg)
        else $error("accepted request left no pending result");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && out_free) |=> m_tvalid_reg)
        else $error("pending result was not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> $stable(data_reg) && $stable(count_reg))
        else $error("waiting result was overwritten");

endmodule

### rtl/deq_core.sv
// Ring store of the deque: head pointer, entry count and the synchronous store memory.
// Depends on deq_pkg for sizes, operation codes and the result record.
module deq_core
    import deq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_en,
    input  logic [KIND_W-1:0] kind,
    input  logic [DATA_W-1:0] value,
    output logic [DATA_W-1:0] rd_data,
    output res_t              res
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    res_t              res_reg, res_next;

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              full, empty;
    logic [ADDR_W-1:0] head_dec, head_inc, tail_idx, last_idx, addr;
    logic [CNT_W:0]    tail_sum, last_sum;
    logic              mem_we, mem_re;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign head_dec = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // Both sums stay below twice the depth, so one conditional subtract wraps them.
    assign tail_sum = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
    assign last_sum = tail_sum - 1'b1;
    assign tail_idx = (tail_sum >= (CNT_W+1)'(DEPTH))
                      ? ADDR_W'(tail_sum - (CNT_W+1)'(DEPTH)) : ADDR_W'(tail_sum);
    assign last_idx = (last_sum >= (CNT_W+1)'(DEPTH))
                      ? ADDR_W'(last_sum - (CNT_W+1)'(DEPTH)) : ADDR_W'(last_sum);

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        addr           = head_reg;
        res_next.sel    = SEL_ZERO;
        res_next.status = ST_OK;
        case (kind)
            KIND_PUSH_FRONT:
            begin
                if (full)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    addr       = head_dec;
                    head_next  = head_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_PUSH_BACK:
            begin
                if (full)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    addr       = tail_idx;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_POP_FRONT, KIND_PEEK_FRONT:
            begin
                if (empty)
                begin
                    res_next.sel    = SEL_EMPTY;
                    res_next.status = ST_EMPTY;
                end
                else
                begin
                    mem_re       = 1'b1;
                    addr         = head_reg;
                    res_next.sel = SEL_MEM;
                    if (kind == KIND_POP_FRONT)
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            KIND_POP_BACK, KIND_PEEK_BACK:
            begin
                if (empty)
                begin
                    res_next.sel    = SEL_EMPTY;
                    res_next.status = ST_EMPTY;
                end
                else
                begin
                    mem_re       = 1'b1;
                    addr         = last_idx;
                    res_next.sel = SEL_MEM;
                    if (kind == KIND_POP_BACK)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                res_next.sel    = SEL_ZERO;
                res_next.status = ST_OK;
            end
        endcase
        res_next.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (op_en)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_en && mem_we)
        begin
            mem[addr] <= value;
        end
        if (op_en && mem_re)
        begin
            rd_data_reg <= mem[addr];
        end
        if (op_en)
        begin
            res_reg <= res_next;
        end
    end

    assign rd_data = rd_data_reg;
    assign res     = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("deque count exceeds the store depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(head_reg) < DEPTH)
        else $error("head pointer outside the store");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (op_en && !full && (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("accepted push did not grow the count");

    a_pop_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (op_en && empty && kind != KIND_PUSH_FRONT && kind != KIND_PUSH_BACK)
        |=> (count_reg == '0 && head_reg == $past(head_reg)))
        else $error("operation on an empty deque changed the state");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the double_ended_queue top level.
// It needs deq_pkg and the RTL only. Results are predicted in a scoreboard class,
// and plain tasks drive random request streams with idle bursts on both sides.
`timescale 1ns / 100ps

module tb_top;
    import deq_pkg::*;

    // Kinds with no operation; the deque leaves its state alone for them.
    localparam logic [KIND_W-1:0] KIND_NONE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_NONE_B = 3'd7;

    localparam int TOTAL_REQUESTS = 1150;
    localparam int CALM_REQUESTS  = 200;
    localparam int HOLD_CYCLES    = 80;

    typedef struct packed {
        logic [DATA_W-1:0]    data;
        logic [STATUS_W-1:0]  status;
        logic [OUT_CNT_W-1:0] count;
    } deq_result_t;

    class deque_scoreboard;
        logic [DATA_W-1:0] ring [DEPTH];
        logic [ADDR_W-1:0] front;
        logic [CNT_W-1:0]  fill;
        deq_result_t       awaited_results [$];
        int unsigned       mismatches;
        int unsigned       accepted;

        function new();
            front = '0;
            fill = '0;
            mismatches = 0;
            accepted = 0;
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        // Works out the result of one accepted request and queues it.
        function void note_request(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] value);
            deq_result_t       r;
            logic [ADDR_W-1:0] slot;
            r.data = '0;
            r.status = ST_OK;
            accepted++;
            case (kind)
                KIND_PUSH_FRONT, KIND_PUSH_BACK:
                begin
                    if (fill >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        if (kind == KIND_PUSH_FRONT)
                        begin
                            front = front - 1'b1;
                            slot = front;
                        end
                        else
                            slot = front + fill[ADDR_W-1:0];
                        ring[slot] = value;
                        fill = fill + 1'b1;
                    end
                end
                KIND_POP_FRONT, KIND_PEEK_FRONT, KIND_POP_BACK, KIND_PEEK_BACK:
                begin
                    if (fill == 0)
                    begin
                        r.data = EMPTY_DATA;
                        r.status = ST_EMPTY;
                    end
                    else if (kind == KIND_POP_FRONT || kind == KIND_PEEK_FRONT)
                    begin
                        r.data = ring[front];
                        if (kind == KIND_POP_FRONT)
                        begin
                            front = front + 1'b1;
                            fill = fill - 1'b1;
                        end
                    end
                    else
                    begin
                        // With a full deque the low count bits are zero, so this wraps
                        // to the slot just before the front.
                        slot = front + fill[ADDR_W-1:0] - 1'b1;
                        r.data = ring[slot];
                        if (kind == KIND_POP_BACK)
                            fill = fill - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            r.count = OUT_CNT_W'(fill);
            awaited_results = {awaited_results, r};
        endfunction

        function void report(string what, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic [STATUS_W-1:0] tuser);
            deq_result_t r;
            if (awaited_results.size() == 0)
            begin
                report("unrequested result", '0, tdata[DATA_W-1:0]);
                return;
            end
            r = awaited_results[0];
            awaited_results.delete(0);
            if (tdata[DATA_W-1:0] !== r.data)
                report("data", r.data, tdata[DATA_W-1:0]);
            if (tuser !== r.status)
                report("status", DATA_W'(r.status), DATA_W'(tuser));
            if (tdata[DATA_W+OUT_CNT_W-1:DATA_W] !== r.count)
                report("count", DATA_W'(r.count), DATA_W'(tdata[DATA_W+OUT_CNT_W-1:DATA_W]));
            if (tdata[OUT_TDATA_W-1:DATA_W+OUT_CNT_W] !== '0)
                report("padding", '0, DATA_W'(tdata[OUT_TDATA_W-1:DATA_W+OUT_CNT_W]));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata = '0;
    logic [KIND_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    bit calm = 1'b0;

    deque_scoreboard sb = new();

    double_ended_queue u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Both handshakes are observed here so that a request is always noted before
    // any later result in the same cycle is checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
        end
    end

    // Result side: random stalls, one long hold-off, always ready at the end.
    initial
    begin : result_sink
        bit held_off;
        held_off = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (calm)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else if (!held_off && sb.accepted >= 300)
            begin
                // The sender keeps offering requests, so the deque has to stall its input.
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held_off = 1'b1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // Offers one request and returns at the edge where it is taken.
    task automatic send_request(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= value;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [KIND_W-1:0] pick_kind(int unsigned push_pct);
        if ($urandom_range(0, 99) < 3)
            return $urandom_range(0, 1) ? KIND_NONE_A : KIND_NONE_B;
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        case ($urandom_range(0, 3))
            0: return KIND_POP_FRONT;
            1: return KIND_POP_BACK;
            2: return KIND_PEEK_FRONT;
            default: return KIND_PEEK_BACK;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 7) != 0)
            return $urandom();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    initial
    begin : request_source
        int unsigned push_pct;
        int          gap;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Empty deque, kinds with no operation, then extreme values at both ends.
        send_request(KIND_POP_FRONT, 32'h1234_5678);
        send_request(KIND_POP_BACK, 32'h0);
        send_request(KIND_PEEK_FRONT, 32'hFFFF_FFFF);
        send_request(KIND_PEEK_BACK, 32'h0);
        send_request(KIND_NONE_A, 32'h5555_5555);
        send_request(KIND_NONE_B, 32'hAAAA_AAAA);
        send_request(KIND_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(KIND_PUSH_BACK, 32'h8000_0000);
        send_request(KIND_PEEK_FRONT, 32'h0);
        send_request(KIND_PEEK_BACK, 32'h0);
        // Fill to the brim, then push at both ends of a full deque.
        for (int i = 0; i < DEPTH - 2; i++)
            send_request(i[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT, pick_value());
        send_request(KIND_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(KIND_PUSH_BACK, 32'h0000_0001);
        send_request(KIND_POP_BACK, 32'h0);
        send_request(KIND_POP_FRONT, 32'h0);
        drain_results();

        push_pct = 50;
        for (int i = 0; i < TOTAL_REQUESTS; i++)
        begin
            // Phases that lean toward pushes or pops walk the deque between full and empty.
            if (i % 40 == 0)
                case ($urandom_range(0, 2))
                    0: push_pct = 15;
                    1: push_pct = 50;
                    default: push_pct = 85;
                endcase
            if (i == TOTAL_REQUESTS - CALM_REQUESTS)
                calm = 1'b1;
            if (i == TOTAL_REQUESTS / 2)
                drain_results();
            send_request(pick_kind(push_pct), pick_value());
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 13);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;

        gap = 0;
        while (sb.pending() != 0 && gap < 5000)
        begin
            @(posedge clk);
            gap++;
        end
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
